### sv/hbq_pkg.sv
// hbq_pkg: field widths, codes and register reset values for the heart beat qualifier.
// No dependencies; the interfaces, the top level and the checker import it.
package hbq_pkg;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int TIME_W  = 32;
    localparam int IR_W    = 18;
    localparam int MG_W    = 14;
    localparam int BPM_W   = 8;
    localparam int VERD_W  = 3;
    localparam int STAT_W  = 4;
    localparam int MINI_W  = 11;
    localparam int LIM_W   = 8;
    localparam int WIN_W   = 16;
    localparam int PADDR_W = 5;
    localparam int CNT4_W  = 4;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [BPM_W-1:0]  t_bpm;

    // Event codes
    localparam logic [FUNC_W-1:0] FN_IR     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_MOTION = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FALL   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ARM    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_TICK   = 3'd4;

    // Beat status codes
    localparam logic [STAT_W-1:0] ST_NONE     = 4'd0;
    localparam logic [STAT_W-1:0] ST_ACCEPTED = 4'd1;
    localparam logic [STAT_W-1:0] ST_WARMUP   = 4'd2;
    localparam logic [STAT_W-1:0] ST_SOON     = 4'd3;
    localparam logic [STAT_W-1:0] ST_MOTION   = 4'd4;
    localparam logic [STAT_W-1:0] ST_OUTLIER  = 4'd5;
    localparam logic [STAT_W-1:0] ST_RANGE    = 4'd6;
    localparam logic [STAT_W-1:0] ST_FIRST    = 4'd7;
    localparam logic [STAT_W-1:0] ST_GATED    = 4'd8;

    // Verdict codes (signed)
    localparam logic signed [VERD_W-1:0] VD_NONE  = 3'sd0;
    localparam logic signed [VERD_W-1:0] VD_SPIKE = 3'sd2;
    localparam logic signed [VERD_W-1:0] VD_FLAT  = -3'sd1;

    // Register indexes
    localparam logic [2:0] RG_ABSENT = 3'd0;
    localparam logic [2:0] RG_STABLE = 3'd1;
    localparam logic [2:0] RG_MININT = 3'd2;
    localparam logic [2:0] RG_OUTLIM = 3'd3;
    localparam logic [2:0] RG_MOTLIM = 3'd4;
    localparam logic [2:0] RG_SPIKE  = 3'd5;
    localparam logic [2:0] RG_FLAT   = 3'd6;
    localparam logic [2:0] RG_FALL   = 3'd7;

    // Register reset values
    localparam logic [IR_W-1:0]   RST_ABSENT = 18'd5000;
    localparam logic [IR_W-1:0]   RST_STABLE = 18'd60000;
    localparam logic [MINI_W-1:0] RST_MININT = 11'd400;
    localparam logic [LIM_W-1:0]  RST_OUTLIM = 8'd15;
    localparam logic [MG_W-1:0]   RST_MOTLIM = 14'd1080;
    localparam logic [LIM_W-1:0]  RST_SPIKE  = 8'd15;
    localparam logic [WIN_W-1:0]  RST_FLAT   = 16'd10000;
    localparam logic [WIN_W-1:0]  RST_FALL   = 16'd2000;
    localparam logic [MG_W-1:0]   RST_PEAK   = 14'd1000;

    // Fixed timing and rate limits
    localparam t_time RATE_CAP_MS = 32'd10;
    localparam t_time GAP_MIN     = 32'd400;
    localparam t_time GAP_MAX     = 32'd1500;
    localparam int    BASE_MIN_REF = 10;

    // Shared divider geometry
    localparam int DVD_W  = 17;
    localparam int DVS_W  = 12;
    localparam int DCNT_W = 5;
    localparam logic [DVD_W-1:0] BPM_NUM = 17'd120000;

endpackage

### sv/hbq_in_if.sv
// hbq_in_if / hbq_out_if: valid-ready channels for events and results.
// Depends on hbq_pkg for field widths.
interface hbq_in_if import hbq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] time_ms;
    logic [IR_W-1:0]   ir_level;
    logic              beat_seen;
    logic [MG_W-1:0]   motion_mg;

    modport source (output valid, func, time_ms, ir_level, beat_seen, motion_mg,
                    input ready);
    modport sink   (input valid, func, time_ms, ir_level, beat_seen, motion_mg,
                    output ready);
endinterface

interface hbq_out_if import hbq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [BPM_W-1:0]         smooth_bpm;
    logic [BPM_W-1:0]         quick_bpm;
    logic signed [VERD_W-1:0] verdict;
    logic                     watching;
    logic                     baseline_full;
    logic [STAT_W-1:0]        beat_status;

    modport source (output valid, smooth_bpm, quick_bpm, verdict, watching,
                    baseline_full, beat_status, input ready);
    modport sink   (input valid, smooth_bpm, quick_bpm, verdict, watching,
                    baseline_full, beat_status, output ready);
endinterface

### sv/heart_beat_qualifier.sv
// heart_beat_qualifier: beat qualification, rate averaging, baseline and response window.
// Depends on hbq_pkg and the hbq_in_if / hbq_out_if channels.
//
// Usage:
//   i_evt carries one timestamped event per request (IR sample, motion, fall, arm,
//   one-second tick). o_res returns exactly one result per event: smoothed and fast
//   rate, window verdict and armed flag, baseline-full flag and beat status.
//   An APB port (always ready) reads and writes the eight limits; write only while idle.
//   Work per request: events that touch no store are evaluated and finished; a tick
//   that feeds the baseline adds one push, an arm that averages the baseline one
//   division, and a beat uses the shared restoring divider: one division for the beat
//   rate, then one per averaged store that is pushed.
//   Averages use running sums; stores live in two single-port memories (rate stores,
//   baseline) with a registered read, one read and one write per push.
//   One event is worked at a time; the next request is taken once the result is in
//   the output register, so a stalled receiver holds only that register. A result
//   held by the receiver blocks the following event at its final step.
//   Reset (synchronous, active low) clears all tracking, sets the limits to their
//   defaults and empties the output register; no clearing pass is needed.
module heart_beat_qualifier import hbq_pkg::*; #(
    parameter int SMOOTH_DEPTH   = 10,
    parameter int FAST_DEPTH     = 3,
    parameter int BASE_DEPTH     = 60,
    parameter int WARMUP_BEATS   = 6,
    parameter int STEADY_SAMPLES = 10,
    parameter int MOTION_HOLD_MS = 150
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hbq_in_if.sink             i_evt,
    hbq_out_if.source          o_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Store geometry
    localparam int SPW    = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
    localparam int FPW    = (FAST_DEPTH > 1) ? $clog2(FAST_DEPTH) : 1;
    localparam int BPW    = (BASE_DEPTH > 1) ? $clog2(BASE_DEPTH) : 1;
    localparam int SCW    = $clog2(SMOOTH_DEPTH + 1);
    localparam int FCW    = $clog2(FAST_DEPTH + 1);
    localparam int BCW    = $clog2(BASE_DEPTH + 1);
    localparam int SSW    = $clog2(SMOOTH_DEPTH * 255 + 1);
    localparam int FSW    = $clog2(FAST_DEPTH * 255 + 1);
    localparam int BSW    = $clog2(BASE_DEPTH * 255 + 1);
    localparam int RDEPTH = SMOOTH_DEPTH + FAST_DEPTH;
    localparam int RAW    = $clog2(RDEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_POST = 3'd3;
    localparam logic [2:0] S_PRD  = 3'd4;
    localparam logic [2:0] S_PWR  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    // Continuations after a division or push
    localparam logic [2:0] C_BPM    = 3'd0;
    localparam logic [2:0] C_FAST1  = 3'd1;
    localparam logic [2:0] C_SMOOTH = 3'd2;
    localparam logic [2:0] C_FAST2  = 3'd3;
    localparam logic [2:0] C_ARM    = 3'd4;
    localparam logic [2:0] C_BASE   = 3'd5;

    // Push targets
    localparam logic [1:0] TG_SMOOTH = 2'd0;
    localparam logic [1:0] TG_FAST   = 2'd1;
    localparam logic [1:0] TG_BASE   = 2'd2;

    // Control registers
    logic [2:0]          r_state, n_state;
    logic [2:0]          r_cont, n_cont;
    logic [1:0]          r_tgt, n_tgt;
    logic                r_o_valid, n_o_valid;
    logic [IR_W-1:0]     r_cfg_absent;
    logic [IR_W-1:0]     r_cfg_stable;
    logic [MINI_W-1:0]   r_cfg_minint;
    logic [LIM_W-1:0]    r_cfg_outlim;
    logic [MG_W-1:0]     r_cfg_motlim;
    logic [LIM_W-1:0]    r_cfg_spike;
    logic [WIN_W-1:0]    r_cfg_flat;
    logic [WIN_W-1:0]    r_cfg_fall;
    logic [SPW-1:0]      r_sm_pos, n_sm_pos;
    logic [SCW-1:0]      r_sm_cnt, n_sm_cnt;
    logic [SSW-1:0]      r_sm_sum, n_sm_sum;
    logic [FPW-1:0]      r_fa_pos, n_fa_pos;
    logic [FCW-1:0]      r_fa_cnt, n_fa_cnt;
    logic [FSW-1:0]      r_fa_sum, n_fa_sum;
    logic [BPW-1:0]      r_ba_pos, n_ba_pos;
    logic [BCW-1:0]      r_ba_cnt, n_ba_cnt;
    logic [BSW-1:0]      r_ba_sum, n_ba_sum;
    t_bpm                r_rate_now, n_rate_now;
    t_bpm                r_rate_fast, n_rate_fast;
    t_bpm                r_ref, n_ref;
    logic [CNT4_W-1:0]   r_warm_cnt, n_warm_cnt;
    logic                r_warm_done, n_warm_done;
    t_time               r_last_beat, n_last_beat;
    logic                r_finger_on, n_finger_on;
    logic                r_steady, n_steady;
    logic [CNT4_W-1:0]   r_steady_cnt, n_steady_cnt;
    logic                r_fall_act, n_fall_act;
    t_time               r_fall_ms, n_fall_ms;
    logic                r_armed, n_armed;
    t_time               r_arm_ms, n_arm_ms;
    logic signed [VERD_W-1:0] r_verdict, n_verdict;
    logic [MG_W-1:0]     r_peak_mg, n_peak_mg;
    t_time               r_peak_ms, n_peak_ms;
    t_time               r_last_smp, n_last_smp;

    // Payload registers
    logic [FUNC_W-1:0]   r_func;
    t_time               r_now;
    logic [IR_W-1:0]     r_ir;
    logic                r_beat;
    logic [MG_W-1:0]     r_mg;
    t_bpm                r_bpm, n_bpm;
    t_bpm                r_push_val, n_push_val;
    logic [STAT_W-1:0]   r_status, n_status;
    logic [DVD_W-1:0]    r_dq, n_dq;
    logic [DVS_W-1:0]    r_dr, n_dr;
    logic [DVS_W-1:0]    r_dd, n_dd;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    t_bpm                r_o_smooth, r_o_quick;
    logic signed [VERD_W-1:0] r_o_verdict;
    logic                r_o_watch, r_o_full;
    logic [STAT_W-1:0]   r_o_status;
    t_bpm                r_rate_rd, r_base_rd;

    // Memories
    t_bpm                m_rate [RDEPTH];
    t_bpm                m_base [BASE_DEPTH];

    logic                w_acc, w_cfg_we, w_load_out;
    logic                w_rate_we, w_base_we;
    logic [RAW-1:0]      w_rate_addr;
    t_time               w_d_fall, w_d_smp, w_gap, w_d_arm, w_d_peak;
    logic                w_win_base, w_spike, w_flat, w_outl;
    logic [BPM_W:0]      w_ref_plus, w_bpm_plus, w_now_plus;
    logic                w_ge;
    logic [DVS_W:0]      w_trial;
    logic [DVS_W-1:0]    w_rem;
    logic [DVD_W-1:0]    w_quo;
    logic                w_sm_full, w_fa_full, w_ba_full;
    t_bpm                w_old;
    logic                do_win, do_clear;
    logic [CNT4_W-1:0]   w_cnt_inc;

    // Channel handshakes
    assign i_evt.ready = (r_state == S_IDLE);
    assign w_acc       = i_evt.valid & i_evt.ready;
    assign pready      = 1'b1;
    assign w_cfg_we    = psel & penable & pwrite;

    assign o_res.valid         = r_o_valid;
    assign o_res.smooth_bpm    = r_o_smooth;
    assign o_res.quick_bpm     = r_o_quick;
    assign o_res.verdict       = r_o_verdict;
    assign o_res.watching      = r_o_watch;
    assign o_res.baseline_full = r_o_full;
    assign o_res.beat_status   = r_o_status;

    // Register read mux
    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            RG_ABSENT: prdata = 32'(r_cfg_absent);
            RG_STABLE: prdata = 32'(r_cfg_stable);
            RG_MININT: prdata = 32'(r_cfg_minint);
            RG_OUTLIM: prdata = 32'(r_cfg_outlim);
            RG_MOTLIM: prdata = 32'(r_cfg_motlim);
            RG_SPIKE:  prdata = 32'(r_cfg_spike);
            RG_FLAT:   prdata = 32'(r_cfg_flat);
            RG_FALL:   prdata = 32'(r_cfg_fall);
        endcase
    end

    // Time differences, all modulo 2^32
    assign w_d_fall = r_now - r_fall_ms;
    assign w_d_smp  = r_now - r_last_smp;
    assign w_gap    = r_now - r_last_beat;
    assign w_d_arm  = r_now - r_arm_ms;
    assign w_d_peak = r_now - r_peak_ms;

    // Window check terms
    assign w_ref_plus = {1'b0, r_ref} + {1'b0, r_cfg_spike};
    assign w_win_base = r_armed && (r_rate_fast != '0) && (r_fa_cnt == FCW'(FAST_DEPTH));
    assign w_spike    = ({1'b0, r_rate_fast} >= w_ref_plus);
    assign w_flat     = (w_d_arm > TIME_W'(r_cfg_flat));

    // Outlier test against the smoothed rate
    assign w_bpm_plus = {1'b0, r_bpm} + {1'b0, r_cfg_outlim};
    assign w_now_plus = {1'b0, r_rate_now} + {1'b0, r_cfg_outlim};
    assign w_outl     = (r_rate_now != '0) &&
                        (({1'b0, r_bpm} > w_now_plus) || ({1'b0, r_rate_now} > w_bpm_plus));

    // Restoring divider step
    assign w_trial = {r_dr, r_dq[DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dd});
    assign w_rem   = w_ge ? DVS_W'(w_trial - {1'b0, r_dd}) : w_trial[DVS_W-1:0];
    assign w_quo   = {r_dq[DVD_W-2:0], w_ge};

    // Store fill and memory addressing
    assign w_sm_full   = (r_sm_cnt == SCW'(SMOOTH_DEPTH));
    assign w_fa_full   = (r_fa_cnt == FCW'(FAST_DEPTH));
    assign w_ba_full   = (r_ba_cnt == BCW'(BASE_DEPTH));
    assign w_rate_addr = (r_tgt == TG_FAST) ? RAW'(RAW'(SMOOTH_DEPTH) + RAW'(r_fa_pos))
                                            : RAW'(r_sm_pos);
    assign w_rate_we   = (r_state == S_PWR) && (r_tgt != TG_BASE);
    assign w_base_we   = (r_state == S_PWR) && (r_tgt == TG_BASE);
    assign w_load_out  = (r_state == S_FIN) && (!r_o_valid || o_res.ready);

    always_comb begin
        unique case (r_tgt)
            TG_SMOOTH: w_old = w_sm_full ? r_rate_rd : '0;
            TG_FAST:   w_old = w_fa_full ? r_rate_rd : '0;
            default:   w_old = w_ba_full ? r_base_rd : '0;
        endcase
    end

    // Sequencer: evaluate, divide, push, finish
    always_comb begin
        n_state      = r_state;
        n_cont       = r_cont;
        n_tgt        = r_tgt;
        n_o_valid    = r_o_valid & ~o_res.ready;
        n_sm_pos     = r_sm_pos;
        n_sm_cnt     = r_sm_cnt;
        n_sm_sum     = r_sm_sum;
        n_fa_pos     = r_fa_pos;
        n_fa_cnt     = r_fa_cnt;
        n_fa_sum     = r_fa_sum;
        n_ba_pos     = r_ba_pos;
        n_ba_cnt     = r_ba_cnt;
        n_ba_sum     = r_ba_sum;
        n_rate_now   = r_rate_now;
        n_rate_fast  = r_rate_fast;
        n_ref        = r_ref;
        n_warm_cnt   = r_warm_cnt;
        n_warm_done  = r_warm_done;
        n_last_beat  = r_last_beat;
        n_finger_on  = r_finger_on;
        n_steady     = r_steady;
        n_steady_cnt = r_steady_cnt;
        n_fall_act   = r_fall_act;
        n_fall_ms    = r_fall_ms;
        n_armed      = r_armed;
        n_arm_ms     = r_arm_ms;
        n_verdict    = r_verdict;
        n_peak_mg    = r_peak_mg;
        n_peak_ms    = r_peak_ms;
        n_last_smp   = r_last_smp;
        n_bpm        = r_bpm;
        n_push_val   = r_push_val;
        n_status     = r_status;
        n_dq         = r_dq;
        n_dr         = r_dr;
        n_dd         = r_dd;
        n_dcnt       = r_dcnt;
        do_win       = 1'b0;
        do_clear     = 1'b0;
        w_cnt_inc    = '0;

        if (w_load_out) begin
            n_o_valid = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_state = S_EVAL;
                end
            end

            S_EVAL: begin
                n_status = ST_NONE;
                n_state  = S_FIN;
                case (r_func)
                    FN_IR: begin
                        n_status = ST_GATED;
                        if (r_fall_act && (w_d_fall < TIME_W'(r_cfg_fall))) begin
                            n_status = ST_GATED;
                        end else begin
                            n_fall_act = 1'b0;
                            if (r_ir < r_cfg_absent) begin
                                do_clear = r_finger_on;
                            end else if (!r_steady) begin
                                n_finger_on = 1'b1;
                                if (r_ir > r_cfg_stable) begin
                                    w_cnt_inc = (r_steady_cnt == '1) ? r_steady_cnt
                                                                     : r_steady_cnt + 1'b1;
                                    n_steady_cnt = w_cnt_inc;
                                    if (w_cnt_inc >= CNT4_W'(STEADY_SAMPLES)) begin
                                        n_steady = 1'b1;
                                    end
                                end else begin
                                    n_steady_cnt = '0;
                                end
                            end else if (w_d_smp < RATE_CAP_MS) begin
                                n_finger_on = 1'b1;
                            end else begin
                                n_finger_on = 1'b1;
                                n_last_smp  = r_now;
                                if (!r_beat) begin
                                    n_status = ST_NONE;
                                end else if (r_last_beat == '0) begin
                                    n_last_beat = r_now;
                                    n_status    = ST_FIRST;
                                end else if (r_peak_mg > r_cfg_motlim) begin
                                    n_status = ST_MOTION;
                                end else if (w_gap < TIME_W'(r_cfg_minint)) begin
                                    n_status = ST_SOON;
                                end else if (w_gap < GAP_MIN || w_gap > GAP_MAX) begin
                                    n_last_beat = r_now;
                                    n_status    = ST_RANGE;
                                end else begin
                                    // rate = (120000 + gap) / (2 * gap)
                                    n_dq    = BPM_NUM + DVD_W'(w_gap[MINI_W-1:0]);
                                    n_dr    = '0;
                                    n_dd    = {w_gap[DVS_W-2:0], 1'b0};
                                    n_dcnt  = DCNT_W'(DVD_W - 1);
                                    n_cont  = C_BPM;
                                    n_state = S_DIV;
                                end
                            end
                        end
                    end
                    FN_MOTION: begin
                        if (r_mg > r_peak_mg || w_d_peak > TIME_W'(MOTION_HOLD_MS)) begin
                            n_peak_mg = r_mg;
                            n_peak_ms = r_now;
                        end
                    end
                    FN_FALL: begin
                        n_fall_act = 1'b1;
                        n_fall_ms  = r_now;
                    end
                    FN_ARM: begin
                        n_armed     = 1'b1;
                        n_arm_ms    = r_now;
                        n_verdict   = VD_NONE;
                        n_fa_pos    = '0;
                        n_fa_cnt    = '0;
                        n_fa_sum    = '0;
                        n_rate_fast = '0;
                        if (r_ba_cnt >= BCW'(BASE_MIN_REF)) begin
                            n_dq    = DVD_W'(r_ba_sum);
                            n_dr    = '0;
                            n_dd    = DVS_W'(r_ba_cnt);
                            n_dcnt  = DCNT_W'(DVD_W - 1);
                            n_cont  = C_ARM;
                            n_state = S_DIV;
                        end else begin
                            n_ref = r_rate_now;
                        end
                    end
                    FN_TICK: begin
                        do_win = (r_rate_now != '0);
                        if (r_rate_now != '0) begin
                            n_push_val = r_rate_now;
                            n_tgt      = TG_BASE;
                            n_cont     = C_BASE;
                            n_state    = S_PRD;
                        end
                    end
                    default: begin
                        n_status = ST_NONE;
                    end
                endcase
            end

            S_DIV: begin
                n_dq   = w_quo;
                n_dr   = w_rem;
                n_dcnt = r_dcnt - 1'b1;
                if (r_dcnt == '0) begin
                    n_state = S_POST;
                    case (r_cont)
                        C_BPM:            n_bpm       = w_quo[BPM_W-1:0];
                        C_SMOOTH:         n_rate_now  = w_quo[BPM_W-1:0];
                        C_ARM:            n_ref       = w_quo[BPM_W-1:0];
                        default:          n_rate_fast = w_quo[BPM_W-1:0];
                    endcase
                end
            end

            S_POST: begin
                case (r_cont)
                    C_BPM: begin
                        if (!r_warm_done) begin
                            w_cnt_inc   = (r_warm_cnt == '1) ? r_warm_cnt : r_warm_cnt + 1'b1;
                            n_warm_cnt  = w_cnt_inc;
                            n_last_beat = r_now;
                            if (w_cnt_inc >= CNT4_W'(WARMUP_BEATS)) begin
                                n_warm_done = 1'b1;
                            end
                            n_status = ST_WARMUP;
                            n_state  = S_FIN;
                        end else if (r_armed) begin
                            n_push_val = r_bpm;
                            n_tgt      = TG_FAST;
                            n_cont     = C_FAST1;
                            n_state    = S_PRD;
                        end else if (w_outl) begin
                            n_status = ST_OUTLIER;
                            n_state  = S_FIN;
                        end else begin
                            n_last_beat = r_now;
                            n_push_val  = r_bpm;
                            n_tgt       = TG_SMOOTH;
                            n_cont      = C_SMOOTH;
                            n_state     = S_PRD;
                        end
                    end
                    C_FAST1: begin
                        do_win = 1'b1;
                        if (w_outl) begin
                            n_status = ST_OUTLIER;
                            n_state  = S_FIN;
                        end else begin
                            n_last_beat = r_now;
                            n_push_val  = r_bpm;
                            n_tgt       = TG_SMOOTH;
                            n_cont      = C_SMOOTH;
                            n_state     = S_PRD;
                        end
                    end
                    C_SMOOTH: begin
                        n_status = ST_ACCEPTED;
                        if (!r_armed) begin
                            n_push_val = r_bpm;
                            n_tgt      = TG_FAST;
                            n_cont     = C_FAST2;
                            n_state    = S_PRD;
                        end else begin
                            do_win  = 1'b1;
                            n_state = S_FIN;
                        end
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end

            S_PRD: begin
                n_state = S_PWR;
            end

            S_PWR: begin
                n_dr   = '0;
                n_dcnt = DCNT_W'(DVD_W - 1);
                n_state = S_DIV;
                unique case (r_tgt)
                    TG_SMOOTH: begin
                        n_sm_sum = r_sm_sum - SSW'(w_old) + SSW'(r_push_val);
                        n_sm_pos = (r_sm_pos == SPW'(SMOOTH_DEPTH - 1)) ? '0 : r_sm_pos + 1'b1;
                        n_sm_cnt = w_sm_full ? r_sm_cnt : r_sm_cnt + 1'b1;
                        n_dq     = DVD_W'(n_sm_sum);
                        n_dd     = DVS_W'(n_sm_cnt);
                    end
                    TG_FAST: begin
                        n_fa_sum = r_fa_sum - FSW'(w_old) + FSW'(r_push_val);
                        n_fa_pos = (r_fa_pos == FPW'(FAST_DEPTH - 1)) ? '0 : r_fa_pos + 1'b1;
                        n_fa_cnt = w_fa_full ? r_fa_cnt : r_fa_cnt + 1'b1;
                        n_dq     = DVD_W'(n_fa_sum);
                        n_dd     = DVS_W'(n_fa_cnt);
                    end
                    default: begin
                        n_ba_sum = r_ba_sum - BSW'(w_old) + BSW'(r_push_val);
                        n_ba_pos = (r_ba_pos == BPW'(BASE_DEPTH - 1)) ? '0 : r_ba_pos + 1'b1;
                        n_ba_cnt = w_ba_full ? r_ba_cnt : r_ba_cnt + 1'b1;
                        n_state  = S_FIN;
                    end
                endcase
            end

            S_FIN: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Window check: spike verdict first, else flat after the window time
        if (do_win && w_win_base) begin
            if (w_spike) begin
                n_verdict = VD_SPIKE;
                n_armed   = 1'b0;
            end else if (w_flat) begin
                n_verdict = VD_FLAT;
                n_armed   = 1'b0;
            end
        end

        // Finger lost: drop all beat tracking and the fast rate
        if (do_clear) begin
            n_warm_cnt   = '0;
            n_warm_done  = 1'b0;
            n_last_beat  = '0;
            n_sm_pos     = '0;
            n_sm_cnt     = '0;
            n_sm_sum     = '0;
            n_steady_cnt = '0;
            n_steady     = 1'b0;
            n_finger_on  = 1'b0;
            n_rate_now   = '0;
            n_fa_pos     = '0;
            n_fa_cnt     = '0;
            n_fa_sum     = '0;
            n_rate_fast  = '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cont       <= C_BPM;
            r_tgt        <= TG_SMOOTH;
            r_o_valid    <= 1'b0;
            r_cfg_absent <= RST_ABSENT;
            r_cfg_stable <= RST_STABLE;
            r_cfg_minint <= RST_MININT;
            r_cfg_outlim <= RST_OUTLIM;
            r_cfg_motlim <= RST_MOTLIM;
            r_cfg_spike  <= RST_SPIKE;
            r_cfg_flat   <= RST_FLAT;
            r_cfg_fall   <= RST_FALL;
            r_sm_pos     <= '0;
            r_sm_cnt     <= '0;
            r_sm_sum     <= '0;
            r_fa_pos     <= '0;
            r_fa_cnt     <= '0;
            r_fa_sum     <= '0;
            r_ba_pos     <= '0;
            r_ba_cnt     <= '0;
            r_ba_sum     <= '0;
            r_rate_now   <= '0;
            r_rate_fast  <= '0;
            r_ref        <= '0;
            r_warm_cnt   <= '0;
            r_warm_done  <= 1'b0;
            r_last_beat  <= '0;
            r_finger_on  <= 1'b0;
            r_steady     <= 1'b0;
            r_steady_cnt <= '0;
            r_fall_act   <= 1'b0;
            r_fall_ms    <= '0;
            r_armed      <= 1'b0;
            r_arm_ms     <= '0;
            r_verdict    <= VD_NONE;
            r_peak_mg    <= RST_PEAK;
            r_peak_ms    <= '0;
            r_last_smp   <= '0;
        end else begin
            r_state      <= n_state;
            r_cont       <= n_cont;
            r_tgt        <= n_tgt;
            r_o_valid    <= n_o_valid;
            r_sm_pos     <= n_sm_pos;
            r_sm_cnt     <= n_sm_cnt;
            r_sm_sum     <= n_sm_sum;
            r_fa_pos     <= n_fa_pos;
            r_fa_cnt     <= n_fa_cnt;
            r_fa_sum     <= n_fa_sum;
            r_ba_pos     <= n_ba_pos;
            r_ba_cnt     <= n_ba_cnt;
            r_ba_sum     <= n_ba_sum;
            r_rate_now   <= n_rate_now;
            r_rate_fast  <= n_rate_fast;
            r_ref        <= n_ref;
            r_warm_cnt   <= n_warm_cnt;
            r_warm_done  <= n_warm_done;
            r_last_beat  <= n_last_beat;
            r_finger_on  <= n_finger_on;
            r_steady     <= n_steady;
            r_steady_cnt <= n_steady_cnt;
            r_fall_act   <= n_fall_act;
            r_fall_ms    <= n_fall_ms;
            r_armed      <= n_armed;
            r_arm_ms     <= n_arm_ms;
            r_verdict    <= n_verdict;
            r_peak_mg    <= n_peak_mg;
            r_peak_ms    <= n_peak_ms;
            r_last_smp   <= n_last_smp;
            // limits: the user must write them only while idle; the block does not enforce it
            if (w_cfg_we) begin
                unique case (paddr[PADDR_W-1:2])
                    RG_ABSENT: r_cfg_absent <= pwdata[IR_W-1:0];
                    RG_STABLE: r_cfg_stable <= pwdata[IR_W-1:0];
                    RG_MININT: r_cfg_minint <= pwdata[MINI_W-1:0];
                    RG_OUTLIM: r_cfg_outlim <= pwdata[LIM_W-1:0];
                    RG_MOTLIM: r_cfg_motlim <= pwdata[MG_W-1:0];
                    RG_SPIKE:  r_cfg_spike  <= pwdata[LIM_W-1:0];
                    RG_FLAT:   r_cfg_flat   <= pwdata[WIN_W-1:0];
                    RG_FALL:   r_cfg_fall   <= pwdata[WIN_W-1:0];
                endcase
            end
        end
    end

    // Payload: captured request, divider, output register
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_func <= i_evt.func;
            r_now  <= i_evt.time_ms;
            r_ir   <= i_evt.ir_level;
            r_beat <= i_evt.beat_seen;
            r_mg   <= i_evt.motion_mg;
        end
        r_bpm      <= n_bpm;
        r_push_val <= n_push_val;
        r_status   <= n_status;
        r_dq       <= n_dq;
        r_dr       <= n_dr;
        r_dd       <= n_dd;
        r_dcnt     <= n_dcnt;
        if (w_load_out) begin
            r_o_smooth  <= r_rate_now;
            r_o_quick   <= r_rate_fast;
            r_o_verdict <= r_verdict;
            r_o_watch   <= r_armed;
            r_o_full    <= w_ba_full;
            r_o_status  <= r_status;
        end
    end

    // Rate store memory (smooth entries then fast entries)
    always_ff @(posedge i_clk) begin
        if (w_rate_we) begin
            m_rate[w_rate_addr] <= r_push_val;
        end
        r_rate_rd <= m_rate[w_rate_addr];
    end

    // Baseline memory
    always_ff @(posedge i_clk) begin
        if (w_base_we) begin
            m_base[r_ba_pos] <= r_push_val;
        end
        r_base_rd <= m_base[r_ba_pos];
    end

endmodule

### sv/hbq_checker.sv
// hbq_props: port-level assertions for heart_beat_qualifier, attached by bind.
// Depends on hbq_pkg for status and verdict codes.
module hbq_props import hbq_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [BPM_W-1:0]         i_smooth,
    input logic signed [VERD_W-1:0] i_verdict,
    input logic                     i_watching,
    input logic [STAT_W-1:0]        i_status
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_smooth))
        else $error("stalled result changed");

    // An armed window has no verdict yet
    a_watch_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_watching |-> i_verdict == VD_NONE)
        else $error("verdict while window armed");

    // An accepted beat always leaves a smoothed rate
    a_accept_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_ACCEPTED |-> i_smooth != '0)
        else $error("accepted beat with zero smoothed rate");

endmodule

bind heart_beat_qualifier hbq_props u_hbq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_smooth    (o_res.smooth_bpm),
    .i_verdict   (o_res.verdict),
    .i_watching  (o_res.watching),
    .i_status    (o_res.beat_status)
);

### verif/hbq_checker.sv
// hbq_checker: watches the event, result and APB channels of heart_beat_qualifier,
// predicts each result from its own copy of the qualifier state and compares.
// Depends on hbq_pkg and the hbq_in_if / hbq_out_if interfaces.
module hbq_checker import hbq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    hbq_in_if                  evt,
    hbq_out_if                 res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int SMOOTH_N = 10;
    localparam int FAST_N   = 3;
    localparam int BASE_N   = 60;
    localparam int WARM_N   = 6;
    localparam int STEADY_N = 10;
    localparam int HOLD_MS  = 150;

    typedef struct {
        t_bpm                     smooth;
        t_bpm                     quick;
        logic signed [VERD_W-1:0] verdict;
        logic                     watching;
        logic                     full;
        logic [STAT_W-1:0]        status;
    } t_result;

    t_result result_q[$];

    // Limits as last written over APB
    int unsigned lim_absent, lim_stable, lim_minint, lim_outlier;
    int unsigned lim_motion, lim_spike, lim_flat, lim_fall;

    // Qualifier state
    int unsigned smooth_buf[SMOOTH_N], fast_buf[FAST_N], base_buf[BASE_N];
    int unsigned smooth_wp, smooth_n, fast_wp, fast_n, base_wp, base_n;
    int unsigned avg_rate, quick_rate, ref_rate, warm_n, steady_n;
    bit          warmed, finger, steady, fall_on, armed;
    t_time       beat_t, fall_t, arm_t, peak_t, sample_t;
    int          verdict_now;
    int unsigned peak_mg;

    function automatic void fast_reset();
        foreach (fast_buf[i]) fast_buf[i] = 0;
        fast_wp = 0; fast_n = 0; quick_rate = 0;
    endfunction

    function automatic void fast_add(int unsigned bpm);
        int unsigned sum;
        sum = 0;
        fast_buf[fast_wp] = bpm & 8'hFF;
        fast_wp = (fast_wp + 1) % FAST_N;
        if (fast_n < FAST_N) fast_n++;
        for (int i = 0; i < fast_n; i++) sum += fast_buf[i];
        quick_rate = sum / fast_n;
    endfunction

    function automatic void smooth_add(int unsigned bpm);
        int unsigned sum;
        sum = 0;
        smooth_buf[smooth_wp] = bpm & 8'hFF;
        smooth_wp = (smooth_wp + 1) % SMOOTH_N;
        if (smooth_n < SMOOTH_N) smooth_n++;
        for (int i = 0; i < smooth_n; i++) sum += smooth_buf[i];
        avg_rate = sum / smooth_n;
    endfunction

    function automatic void finger_lost();
        warm_n = 0; warmed = 0; beat_t = '0;
        foreach (smooth_buf[i]) smooth_buf[i] = 0;
        smooth_wp = 0; smooth_n = 0;
        steady_n = 0; steady = 0; finger = 0; avg_rate = 0;
        fast_reset();
    endfunction

    // Close the window on a spike over the reference or once the flat window ran out
    function automatic void window_eval(int unsigned bpm, t_time now);
        t_time since;
        since = now - arm_t;
        if (!armed || bpm == 0 || quick_rate == 0 || fast_n < FAST_N) return;
        if (int'(quick_rate) - int'(ref_rate) >= int'(lim_spike)) begin
            verdict_now = 2; armed = 0;
        end else if (since > lim_flat) begin
            verdict_now = -1; armed = 0;
        end
    endfunction

    function automatic logic [STAT_W-1:0] qualify(t_time now, int unsigned ir, bit beat);
        t_time       gap, dt;
        int unsigned bpm;
        int          diff;
        if (fall_on) begin
            dt = now - fall_t;
            if (dt < lim_fall) return ST_GATED;
            fall_on = 0;
        end
        if (ir < lim_absent) begin
            if (finger) finger_lost();
            return ST_GATED;
        end
        finger = 1;
        if (!steady) begin
            if (ir > lim_stable) begin
                if (steady_n < 15) steady_n++;
                if (steady_n >= STEADY_N) steady = 1;
            end else begin
                steady_n = 0;
            end
            return ST_GATED;
        end
        dt = now - sample_t;
        if (dt < RATE_CAP_MS) return ST_GATED;
        sample_t = now;
        if (!beat) return ST_NONE;
        gap = now - beat_t;
        if (beat_t == '0) begin
            beat_t = now;
            return ST_FIRST;
        end
        if (peak_mg > lim_motion) return ST_MOTION;
        if (gap < lim_minint) return ST_SOON;
        if (gap < GAP_MIN || gap > GAP_MAX) begin
            beat_t = now;
            return ST_RANGE;
        end
        bpm = (120000 + gap) / (2 * gap);
        if (!warmed) begin
            if (warm_n < 15) warm_n++;
            beat_t = now;
            if (warm_n >= WARM_N) warmed = 1;
            return ST_WARMUP;
        end
        if (armed) begin
            fast_add(bpm);
            window_eval(bpm, now);
        end
        if (avg_rate > 0) begin
            diff = int'(bpm) - int'(avg_rate);
            if (diff < -int'(lim_outlier) || diff > int'(lim_outlier)) return ST_OUTLIER;
        end
        beat_t = now;
        smooth_add(bpm);
        if (!armed) fast_add(bpm);
        else window_eval(bpm, now);
        return ST_ACCEPTED;
    endfunction

    function automatic void state_reset();
        lim_absent = RST_ABSENT; lim_stable = RST_STABLE; lim_minint = RST_MININT;
        lim_outlier = RST_OUTLIM; lim_motion = RST_MOTLIM; lim_spike = RST_SPIKE;
        lim_flat = RST_FLAT; lim_fall = RST_FALL;
        finger_lost();
        foreach (base_buf[i]) base_buf[i] = 0;
        base_wp = 0; base_n = 0; ref_rate = 0;
        fall_on = 0; fall_t = '0; armed = 0; arm_t = '0; verdict_now = 0;
        peak_mg = RST_PEAK; peak_t = '0; sample_t = '0;
    endfunction

    function automatic void apply_write(logic [2:0] idx, logic [31:0] val);
        case (idx)
            RG_ABSENT: lim_absent  = val[IR_W-1:0];
            RG_STABLE: lim_stable  = val[IR_W-1:0];
            RG_MININT: lim_minint  = val[MINI_W-1:0];
            RG_OUTLIM: lim_outlier = val[LIM_W-1:0];
            RG_MOTLIM: lim_motion  = val[MG_W-1:0];
            RG_SPIKE:  lim_spike   = val[LIM_W-1:0];
            RG_FLAT:   lim_flat    = val[WIN_W-1:0];
            RG_FALL:   lim_fall    = val[WIN_W-1:0];
            default: ;
        endcase
    endfunction

    // One event in, one expected result out
    function automatic t_result predict_event(logic [FUNC_W-1:0] fn, t_time now,
                                              int unsigned ir, bit beat, int unsigned mg);
        t_result     r;
        int unsigned sum;
        t_time       dt;
        r.status = ST_NONE;
        case (fn)
            FN_IR: r.status = qualify(now, ir, beat);
            FN_MOTION: begin
                dt = now - peak_t;
                if (mg > peak_mg || dt > HOLD_MS) begin
                    peak_mg = mg; peak_t = now;
                end
            end
            FN_FALL: begin
                fall_on = 1; fall_t = now;
            end
            FN_ARM: begin
                armed = 1; arm_t = now; verdict_now = 0;
                if (base_n >= BASE_MIN_REF) begin
                    sum = 0;
                    for (int i = 0; i < base_n; i++) sum += base_buf[i];
                    ref_rate = (sum / base_n) & 8'hFF;
                end else begin
                    ref_rate = avg_rate;
                end
                fast_reset();
            end
            FN_TICK: begin
                if (avg_rate > 0) begin
                    base_buf[base_wp] = avg_rate;
                    base_wp = (base_wp + 1) % BASE_N;
                    if (base_n < BASE_N) base_n++;
                end
                if (armed) window_eval(avg_rate, now);
            end
            default: ;
        endcase
        r.smooth   = avg_rate[BPM_W-1:0];
        r.quick    = quick_rate[BPM_W-1:0];
        r.verdict  = verdict_now[VERD_W-1:0];
        r.watching = armed;
        r.full     = (base_n >= BASE_N);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        state_reset();
    end

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            state_reset();
            result_q.delete();
        end else begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr[4:2], pwdata);
            // results are checked before this edge's request is predicted
            if (res.valid && res.ready) begin
                if (result_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = result_q.pop_front();
                    if (res.smooth_bpm !== want.smooth)
                        report_mismatch("smooth_bpm", res.smooth_bpm, want.smooth);
                    if (res.quick_bpm !== want.quick)
                        report_mismatch("quick_bpm", res.quick_bpm, want.quick);
                    if (res.verdict !== want.verdict)
                        report_mismatch("verdict", res.verdict, want.verdict);
                    if (res.watching !== want.watching)
                        report_mismatch("watching", res.watching, want.watching);
                    if (res.baseline_full !== want.full)
                        report_mismatch("baseline_full", res.baseline_full, want.full);
                    if (res.beat_status !== want.status)
                        report_mismatch("beat_status", res.beat_status, want.status);
                end
            end
            if (evt.valid && evt.ready)
                result_q.push_back(predict_event(evt.func, evt.time_ms, evt.ir_level,
                                                 evt.beat_seen, evt.motion_mg));
        end
    end

endmodule

### verif/tb_heart_beat_qualifier.sv
// tb_heart_beat_qualifier: stimulus, APB setup, flow control and verdict for the qualifier.
// Depends on hbq_pkg, the channel interfaces, heart_beat_qualifier and hbq_checker.
module tb_heart_beat_qualifier import hbq_pkg::*; ();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 100;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata, prdata;
    logic               pready;
    int                 errors, pending, cycles;
    int                 send_idle_pct, recv_stall_pct;
    bit                 hold_req;

    // Random stimulus context
    t_time now_ms, tick_due, beat_due;
    int    base_gap;

    hbq_in_if  evt ();
    hbq_out_if res ();

    heart_beat_qualifier dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_evt(evt), .o_res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    hbq_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .evt(evt), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 0;
    always #10 i_clk = ~i_clk;

    // Run limit
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL heart_beat_qualifier");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 0;
        res.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done && hold_left == 0) begin
                hold_left = 600;
                hold_done = 1;
            end
            if (hold_left > 0) begin
                res.ready = 0;
                hold_left--;
            end else begin
                res.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // Offer one request, hold it until accepted
    task automatic send(logic [FUNC_W-1:0] fn, t_time t, logic [IR_W-1:0] ir,
                        logic beat, logic [MG_W-1:0] mg);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            evt.valid = 0;
            @(negedge i_clk);
        end
        evt.valid = 1; evt.func = fn; evt.time_ms = t;
        evt.ir_level = ir; evt.beat_seen = beat; evt.motion_mg = mg;
        do @(posedge i_clk); while (!evt.ready);
    endtask

    task automatic settle();
        @(negedge i_clk);
        evt.valid = 0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(int unsigned absent, int unsigned stable, int unsigned minint,
                             int unsigned outlim, int unsigned motlim, int unsigned spike,
                             int unsigned flat, int unsigned fall);
        apb_write(RG_ABSENT, absent);
        apb_write(RG_STABLE, stable);
        apb_write(RG_MININT, minint);
        apb_write(RG_OUTLIM, outlim);
        apb_write(RG_MOTLIM, motlim);
        apb_write(RG_SPIKE, spike);
        apb_write(RG_FLAT, flat);
        apb_write(RG_FALL, fall);
    endtask

    // One random request, mostly a plausible beat stream with ticks once a second
    task automatic random_event();
        int    pick, adv;
        bit    beat;
        logic [IR_W-1:0] ir;
        pick = $urandom_range(99);
        if (now_ms >= tick_due) begin
            tick_due += 1000;
            send(FN_TICK, now_ms, IR_W'($urandom), 1'($urandom), MG_W'($urandom));
        end else if (pick < 3) begin
            send(FUNC_W'(FN_TICK + $urandom_range(3, 1)), now_ms, IR_W'($urandom),
                 1'($urandom), MG_W'($urandom));
        end else if (pick < 11) begin
            now_ms += $urandom_range(20);
            send(FN_MOTION, now_ms, IR_W'($urandom), 1'($urandom),
                 MG_W'(($urandom_range(4) == 0) ? $urandom_range(16000)
                                                : $urandom_range(1000)));
        end else if (pick < 13) begin
            send(FN_ARM, now_ms, IR_W'($urandom), 1'($urandom), MG_W'($urandom));
        end else if (pick < 14) begin
            send(FN_FALL, now_ms, IR_W'($urandom), 1'($urandom), MG_W'($urandom));
        end else begin
            adv  = $urandom_range(300, 10);
            beat = 0;
            if (now_ms + adv >= beat_due) begin
                now_ms = beat_due;
                beat = 1;
                if ($urandom_range(9) == 0) base_gap = $urandom_range(1450, 420);
                beat_due = now_ms + base_gap + $urandom_range(40) - 20;
                if ($urandom_range(19) == 0) beat_due = now_ms + $urandom_range(3000, 50);
            end else begin
                now_ms += adv;
                beat = ($urandom_range(19) == 0);
            end
            case ($urandom_range(19))
                0:       ir = IR_W'($urandom_range(4999));
                1, 2:    ir = IR_W'($urandom);
                default: ir = IR_W'($urandom_range(262143, 60001));
            endcase
            send(FN_IR, now_ms, ir, beat, MG_W'($urandom));
        end
    endtask

    initial begin
        int phase;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        evt.valid = 0; evt.func = FN_IR; evt.time_ms = '0;
        evt.ir_level = '0; evt.beat_seen = 0; evt.motion_mg = '0;
        send_idle_pct = 0; recv_stall_pct = 0; hold_req = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: field extremes, every event code, unused codes, timestamp wrap
        send(FN_IR, 32'd0, '0, 1'b1, '0);
        send(FN_IR, 32'd5, 18'h3FFFF, 1'b0, 14'h3FFF);
        send(FN_MOTION, 32'd6, '0, 1'b0, 14'd16000);
        send(FN_MOTION, 32'd500, '0, 1'b0, 14'd0);
        for (int i = 0; i < 11; i++)
            send(FN_IR, 32'hFFFF_FF00 + i * 20, 18'h3FFFF, 1'b0, '0);
        send(FN_IR, 32'hFFFF_FFF0, 18'd100000, 1'b1, '0);
        send(FN_IR, 32'h0000_0100, 18'd100000, 1'b1, '0);
        send(FN_IR, 32'h0000_0105, 18'd100000, 1'b1, '0);
        send(FN_ARM, 32'h0000_0200, '0, 1'b0, '0);
        send(FN_TICK, 32'h0000_0300, '0, 1'b0, '0);
        send(FN_FALL, 32'h0000_0400, '0, 1'b0, '0);
        send(FN_IR, 32'h0000_0500, 18'd100000, 1'b1, '0);
        send(FN_TICK + 3'd1, 32'hFFFF_FFFF, 18'h3FFFF, 1'b1, 14'h3FFF);
        send(FN_TICK + 3'd3, 32'h0, '0, 1'b0, '0);
        settle();

        now_ms = 32'd100000; tick_due = 32'd101000; beat_due = 32'd100700;
        base_gap = 700;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: configure(RST_ABSENT, RST_STABLE, RST_MININT, RST_OUTLIM,
                             RST_MOTLIM, RST_SPIKE, RST_FLAT, RST_FALL);
                1: configure(0, 0, 1, 0, 0, 1, 1, 0);
                2: configure(RST_ABSENT, RST_STABLE, 300, 40, 2000, 5, 4000, 500);
                3: configure(262143, 262143, 1500, 150, 16000, 150, 60000, 60000);
                4: configure($urandom_range(20000), $urandom_range(80000), $urandom_range(450, 1),
                             $urandom_range(150), $urandom_range(16000, 1000),
                             $urandom_range(30, 1), $urandom_range(60000, 1),
                             $urandom_range(5000));
                default: configure(RST_ABSENT, 61000, 400, 150, 16000, 8, 20000, 0);
            endcase
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            @(posedge i_clk);
            if (phase == 0) hold_req = 1;
            for (int n = 0; n < PHASE_ITEMS; n++) random_event();
            settle();
        end

        if (errors == 0)
            $display("PASS heart_beat_qualifier");
        else
            $display("FAIL heart_beat_qualifier");
        $finish;
    end

endmodule
